/* sv/mie_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOINV = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic step;
		logic update;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic special_in;
		logic rem_zero;
	} sts_t;

endpackage

`default_nettype wire

/* sv/mie_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module mie_ctrl #(
	parameter int WORD_BITS = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	output mie_pkg::cmd_t      cmd,
	input  wire mie_pkg::sts_t sts
);
	import mie_pkg::*;

	localparam int CW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          accept;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		cmd.load     = accept;
		cmd.step     = (state_q == S_DIV);
		cmd.update   = (state_q == S_UPD) && !sts.rem_zero;
		cmd.out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q   <= CW'(WORD_BITS - 1);
						state_q <= sts.special_in ? S_DONE : S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == '0)
						state_q <= S_UPD;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				S_UPD: begin
					if (sts.rem_zero) begin
						state_q <= S_DONE;
					end else begin
						cnt_q   <= CW'(WORD_BITS - 1);
						state_q <= S_DIV;
					end
				end
				S_DONE: begin
					if (cmd.out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/mie_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module mie_dpath #(
	parameter int WORD_BITS = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [63:0]   value,
	input  wire logic [62:0]   modulus,
	output logic [62:0]        inverse,
	output logic [1:0]         status,
	input  wire mie_pkg::cmd_t cmd,
	output mie_pkg::sts_t      sts
);
	import mie_pkg::*;

	localparam int W = WORD_BITS;

	logic [W-1:0] v_in;
	logic [W-2:0] m_in;
	logic [1:0]   special_in;

	logic [W-1:0] a_sh_q, b_q, rem_q, acc_q, tp_q, tc_q;
	logic [W-2:0] m_q;
	logic [1:0]   special_q;
	logic [62:0]  inverse_q;
	logic [1:0]   status_q;

	logic [W:0]   sh;
	logic [W+1:0] diff;
	logic         qbit;
	logic [W-1:0] rem_next, acc_next, res;
	logic         gcd_one;

	assign v_in = value[W-1:0];
	assign m_in = modulus[W-2:0];

	always_comb begin
		if (v_in == '0)
			special_in = ST_ZERO;
		else if (m_in < (W-1)'(2))
			special_in = ST_NOINV;
		else
			special_in = ST_OK;
	end

	// restoring divide, one quotient bit a cycle; q*t_cur is built by Horner
	// from the same bits, all mod 2^W
	assign sh       = {rem_q, a_sh_q[W-1]};
	assign diff     = {1'b0, sh} - {2'b00, b_q};
	assign qbit     = !diff[W+1];
	assign rem_next = qbit ? diff[W-1:0] : sh[W-1:0];
	assign acc_next = {acc_q[W-2:0], 1'b0} + (qbit ? tc_q : '0);

	assign gcd_one = (b_q == W'(1));
	assign res     = tc_q[W-1] ? (tc_q + {1'b0, m_q}) : tc_q;

	assign sts.special_in = (special_in != ST_OK);
	assign sts.rem_zero   = (rem_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			special_q <= ST_OK;
		end else if (cmd.load) begin
			special_q <= special_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_sh_q <= {1'b0, m_in};
			b_q    <= v_in;
			rem_q  <= '0;
			acc_q  <= '0;
			tp_q   <= '0;
			tc_q   <= W'(1);
			m_q    <= m_in;
		end else if (cmd.step) begin
			a_sh_q <= {a_sh_q[W-2:0], 1'b0};
			rem_q  <= rem_next;
			acc_q  <= acc_next;
		end else if (cmd.update) begin
			tp_q   <= tc_q;
			tc_q   <= tp_q - acc_q;
			a_sh_q <= b_q;
			b_q    <= rem_q;
			rem_q  <= '0;
			acc_q  <= '0;
		end

		if (cmd.out_load) begin
			if (special_q != ST_OK) begin
				status_q  <= special_q;
				inverse_q <= '0;
			end else if (gcd_one) begin
				status_q  <= ST_OK;
				inverse_q <= 63'(res[W-2:0]);
			end else begin
				status_q  <= ST_NOINV;
				inverse_q <= '0;
			end
		end
	end

	assign inverse = inverse_q;
	assign status  = status_q;

endmodule

`default_nettype wire

/* sv/modular_inverse_euclid_core.sv */
// Modular inverse by extended Euclid, one word at a time.
// Each word takes R division rounds (up to ~93 at 64 bits);
// each round is a bit-serial restoring divide followed by an update state.
// Zero value or modulus below two: no divide rounds, straight to the done state.
// A new word is taken only in idle; a result may wait in the output register meanwhile.
// Reset (arst_n, async low) clears controller and valid state; no memories to clear.
`timescale 1ns / 1ps
`default_nettype none

module modular_inverse_euclid_core #(
	parameter int WORD_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] value,
	input  wire logic [62:0] modulus,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [62:0]      inverse,
	output logic [1:0]       status
);
	import mie_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mie_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	mie_dpath #(.WORD_BITS(WORD_BITS)) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.value   (value),
		.modulus (modulus),
		.inverse (inverse),
		.status  (status),
		.cmd     (cmd),
		.sts     (sts)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("not busy after accepting a word");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3))
		else $error("undefined status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (inverse == '0))
		else $error("nonzero inverse on failed word");

	a_out_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> !in_stall)
		else $error("controller did not return to idle after result");

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
	import mie_pkg::*;

	localparam int WORD_BITS = 64;
	localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - WORD_BITS);
	localparam logic [62:0] MOD_MASK = WORD_MASK[63:1];
	localparam int LIMIT_CYCLES = 4_000_000;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic [62:0] inverse;
		logic [1:0]  status;
	} inv_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] value = '0;
	logic [62:0] modulus = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [62:0] inverse;
	logic [1:0]  status;

	inv_result_t pending_inverses[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_left = 0;

	modular_inverse_euclid_core #(
		.WORD_BITS(WORD_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.modulus(modulus),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.inverse(inverse),
		.status(status)
	);

	always #5 clk = ~clk;

	// extended Euclid, coefficients wrap at 64 bits and are read as two's complement
	function automatic inv_result_t predict_inverse(logic [63:0] v_in, logic [62:0] m_in);
		logic [63:0] v, m, a, b, q, r, t_prev, t_cur, t_next;
		inv_result_t res;
		v = v_in & WORD_MASK;
		m = {1'b0, m_in & MOD_MASK};
		res.inverse = '0;
		if (v == 0) begin
			res.status = ST_ZERO;
		end else if (m < 2) begin
			res.status = ST_NOINV;
		end else begin
			a = m;
			b = v;
			t_prev = '0;
			t_cur = 64'd1;
			while (1) begin
				q = a / b;
				r = a % b;
				if (r == 0)
					break;
				t_next = t_prev - q * t_cur;
				t_prev = t_cur;
				t_cur = t_next;
				a = b;
				b = r;
			end
			if (b != 1) begin
				res.status = ST_NOINV;
			end else begin
				if (t_cur[63])
					t_cur = t_cur + m;
				res.inverse = t_cur[62:0];
				res.status = ST_OK;
			end
		end
		return res;
	endfunction

	task automatic add_expected(input inv_result_t r);
		pending_inverses.insert(pending_inverses.size(), r);
	endtask

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input logic [63:0] v, input logic [62:0] m);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		modulus <= m;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		@(negedge clk);
		add_expected(predict_inverse(v, m));
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		while (pending_inverses.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_special_operands();
		send_word(64'd0, 63'd13);
		send_word(64'd0, 63'd0);
		send_word(64'd0, 63'd1);
		send_word(64'd0, {63{1'b1}});
		send_word(64'd5, 63'd0);
		send_word(64'd5, 63'd1);
		send_word({64{1'b1}}, 63'd0);
		stop_sending();
		wait_all_results();
	endtask

	task automatic test_edge_operands();
		send_word(64'd1, 63'd2);
		send_word(64'd3, 63'd2);
		send_word(64'd1, 63'd1000000007);
		send_word(64'd1000000006, 63'd1000000007);
		send_word(64'd1000003, 63'd1000003);
		send_word(64'd6, 63'd9);
		send_word(64'd10, 63'd7);
		send_word({64{1'b1}}, {63{1'b1}});
		send_word(64'd3, {63{1'b1}});
		send_word(64'h8000_0000_0000_0001, 63'd13);
		send_word(64'h5555_5555_5555_5555, 63'd2305843009213693951);
		// consecutive Fibonacci numbers: longest run of division rounds
		send_word(64'd4660046610375530309, 63'd7540113804746346429);
		send_word(64'd7540113804746346429, 63'd4660046610375530309);
		stop_sending();
		wait_all_results();
	endtask

	task automatic send_random_word();
		logic [63:0] v;
		logic [62:0] m;
		int shift;
		bit coprime_only;
		inv_result_t chk;
		shift = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 61);
		m = 63'({$urandom, $urandom} >> shift);
		coprime_only = ($urandom_range(0, 4) != 0);
		if (coprime_only && m < 2)
			m = m | 63'd2;
		if ($urandom_range(0, 3) == 0 || m == 0)
			v = {$urandom, $urandom};
		else
			v = {$urandom, $urandom} % {1'b0, m};
		if (coprime_only) begin
			repeat (8) begin
				chk = predict_inverse(v, m);
				if (chk.status != ST_OK)
					v = {$urandom, $urandom} % {1'b0, m};
			end
		end
		send_word(v, m);
	endtask

	task automatic test_random_traffic();
		int idle_pcts[4] = '{0, 47, 0, 20};
		int stall_pcts[4] = '{0, 0, 47, 20};
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = idle_pcts[phase];
			recv_stall_pct = stall_pcts[phase];
			repeat (19)
				send_random_word();
			stop_sending();
			wait_all_results();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// receiver holds off while words keep coming, so the core and output register fill
	task automatic test_output_holdoff();
		logic [62:0] m;
		@(posedge clk);
		hold_left <= HOLD_CYCLES;
		@(negedge clk);
		repeat (6) begin
			m = 63'($urandom_range(3, 5000));
			send_word(64'($urandom_range(1, 100000)), m);
		end
		stop_sending();
		wait_all_results();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		inv_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_inverses.size() == 0) begin
				$error("unexpected word: inverse %0d status %0d", inverse, status);
				mismatch_count++;
			end else begin
				exp_res = pending_inverses.pop_front();
				if (inverse !== exp_res.inverse) begin
					$error("inverse mismatch: expected %0d, got %0d", exp_res.inverse, inverse);
					mismatch_count++;
				end
				if (status !== exp_res.status) begin
					$error("status mismatch: expected %0d, got %0d", exp_res.status, status);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_special_operands();
		test_edge_operands();
		test_random_traffic();
		test_output_holdoff();
		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_inverses.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
